[hdl/led_strip_frame_engine_assert.svh]
// Assertion macros for the LED strip frame engine.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef LED_STRIP_FRAME_ENGINE_ASSERT_SVH
`define LED_STRIP_FRAME_ENGINE_ASSERT_SVH
`ifndef ASSERT_OFF
`define LSFE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LSFE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LSFE_ASSERT(lbl, clk, rst_n, prop, msg)
`define LSFE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[hdl/lsfe_pkg.sv]
// Shared types, constants and helpers for the LED strip frame engine.
// No dependencies; imported by every module of the block.
`default_nettype none
package lsfe_pkg;

    localparam int MAX_PIXELS  = 16;
    localparam int MAX_TRAILER = 16;
    localparam int PIX_IDX_W   = $clog2(MAX_PIXELS);
    localparam int CNT_W       = $clog2(MAX_PIXELS + 1);
    localparam int TRL_W       = $clog2(MAX_TRAILER + 1);
    localparam int FRAME_MAX   = 3 * MAX_PIXELS + MAX_TRAILER;
    localparam int FRAME_W     = $clog2(FRAME_MAX + 1);
    localparam int DATA_W      = $clog2(3 * MAX_PIXELS + 1);
    localparam int STEPS_W     = 16;
    localparam int ADDR_W      = 5;
    localparam int OQ_DEPTH    = 4;
    localparam int OQ_PTR_W    = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W    = $clog2(OQ_DEPTH + 1);

    localparam logic [1:0] COLOR_RED   = 2'd0;
    localparam logic [1:0] COLOR_GREEN = 2'd1;
    localparam logic [1:0] COLOR_BLUE  = 2'd2;

    localparam logic [2:0] REG_SLOT0      = 3'd0;
    localparam logic [2:0] REG_SLOT1      = 3'd1;
    localparam logic [2:0] REG_SLOT2      = 3'd2;
    localparam logic [2:0] REG_PIXELS     = 3'd3;
    localparam logic [2:0] REG_TRAILER    = 3'd4;
    localparam logic [2:0] REG_BRIGHTNESS = 3'd5;

    localparam logic [7:0] FULL_SCALE = 8'd255;

    typedef enum logic [1:0] {
        OP_SET    = 2'd0,
        OP_FILL   = 2'd1,
        OP_ROTATE = 2'd2,
        OP_SHOW   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_MOD,
        FS_PUSH
    } t_front_state;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROTATE,
        ST_EMIT
    } t_back_state;

    // effective settings, already clamped
    typedef struct packed {
        logic [1:0]       slot0;
        logic [1:0]       slot1;
        logic [1:0]       slot2;
        logic [CNT_W-1:0] pixels;
        logic [TRL_W-1:0] trailer;
        logic [7:0]       brightness;
    } t_cfg;

    // pixel holds wire slot k in bits [8k+7:8k]
    typedef struct packed {
        t_op                  op;
        logic [PIX_IDX_W-1:0] idx;
        logic [23:0]          pixel;
        logic [PIX_IDX_W-1:0] steps;
    } t_cmd;

    function automatic logic [7:0] pick_color(input logic [1:0] sel, input logic [7:0] r,
                                              input logic [7:0] g, input logic [7:0] b);
        logic [7:0] v;
        case (sel)
            COLOR_RED:   v = r;
            COLOR_GREEN: v = g;
            COLOR_BLUE:  v = b;
            default:     v = 8'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

[hdl/lsfe_front.sv]
// Front end: takes one request item, reduces rotate steps modulo the pixel count,
// clamps the index, reorders colours into wire order. Depends on lsfe_pkg.
`default_nettype none
module lsfe_front
    import lsfe_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cfg       i_cfg,
    input  wire logic       i_push,
    output logic            o_full,
    input  wire logic [1:0] i_req_type,
    input  wire logic [PIX_IDX_W-1:0] i_pixel_index,
    input  wire logic [7:0] i_red,
    input  wire logic [7:0] i_green,
    input  wire logic [7:0] i_blue,
    input  wire logic [STEPS_W-1:0] i_rotate_steps,
    input  wire logic       i_q_full,
    output logic            o_q_push,
    output t_cmd            o_cmd
);

    t_front_state r_state, n_state;

    logic [1:0]           r_req;
    logic [PIX_IDX_W-1:0] r_idx;
    logic [7:0]           r_red, r_green, r_blue;
    logic [STEPS_W-1:0]   r_steps;
    logic [PIX_IDX_W-1:0] r_rem, n_rem;
    logic [$clog2(STEPS_W)-1:0] r_bit, n_bit;

    logic                 accept;
    logic [CNT_W-1:0]     trial;
    logic [CNT_W-1:0]     last_pix;

    assign accept   = i_push && (r_state == FS_IDLE);
    assign trial    = {r_rem, r_steps[r_bit]};
    assign last_pix = i_cfg.pixels - CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_bit <= n_bit;
        if (accept) begin
            r_req   <= i_req_type;
            r_idx   <= i_pixel_index;
            r_red   <= i_red;
            r_green <= i_green;
            r_blue  <= i_blue;
            r_steps <= i_rotate_steps;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_rem    = r_rem;
        n_bit    = r_bit;
        o_q_push = 1'b0;
        case (r_state)
            FS_IDLE: begin
                if (i_push) begin
                    n_rem = '0;
                    n_bit = '1;
                    n_state = (t_op'(i_req_type) == OP_ROTATE) ? FS_MOD : FS_PUSH;
                end
            end
            FS_MOD: begin
                // restoring remainder, one step bit per cycle
                n_rem = (trial >= i_cfg.pixels) ? PIX_IDX_W'(trial - i_cfg.pixels)
                                                : PIX_IDX_W'(trial);
                n_bit = r_bit - 1'b1;
                if (r_bit == '0) begin
                    n_state = FS_PUSH;
                end
            end
            FS_PUSH: begin
                if (!i_q_full) begin
                    o_q_push = 1'b1;
                    n_state  = FS_IDLE;
                end
            end
            default: n_state = FS_IDLE;
        endcase
    end

    assign o_full = (r_state != FS_IDLE);

    always_comb begin
        o_cmd.op    = t_op'(r_req);
        o_cmd.idx   = ({1'b0, r_idx} >= i_cfg.pixels) ? PIX_IDX_W'(last_pix) : r_idx;
        o_cmd.pixel = {pick_color(i_cfg.slot2, r_red, r_green, r_blue),
                       pick_color(i_cfg.slot1, r_red, r_green, r_blue),
                       pick_color(i_cfg.slot0, r_red, r_green, r_blue)};
        o_cmd.steps = r_rem;
    end

endmodule
`default_nettype wire

[hdl/lsfe_cmd_fifo.sv]
// Two-entry command queue between the front end and the frame back end.
// Depends on lsfe_pkg for the command type.
`default_nettype none
module lsfe_cmd_fifo
    import lsfe_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_cmd      o_cmd
);

    t_cmd       r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_cmd   = r_mem[r_rptr];

endmodule
`default_nettype wire

[hdl/lsfe_back.sv]
// Back end: pixel store, rotate sequencer, frame emitter with brightness scaling
// and the output queue. Depends on lsfe_pkg and the assertion macro header.
`default_nettype none
`include "led_strip_frame_engine_assert.svh"
module lsfe_back
    import lsfe_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    input  wire logic i_cmd_empty,
    input  wire t_cmd i_cmd,
    output logic      o_cmd_pop,
    output logic      o_empty,
    input  wire logic i_pop,
    output logic [7:0] o_out_byte,
    output logic      o_last_byte
);

    t_back_state r_state, n_state;

    logic [23:0]          r_store [MAX_PIXELS];
    logic [23:0]          n_store [MAX_PIXELS];
    logic [PIX_IDX_W-1:0] r_rem, n_rem;
    logic [FRAME_W-1:0]   r_cnt, n_cnt;
    logic [FRAME_W-1:0]   r_total, n_total;
    logic [DATA_W-1:0]    r_ndata, n_ndata;
    logic [PIX_IDX_W-1:0] r_pix, n_pix;
    logic [1:0]           r_slot, n_slot;
    logic                 r_scaled, n_scaled;

    // scale stage
    logic                 r_pv;
    logic [15:0]          r_prod;
    logic                 r_plast;

    // output queue
    logic [7:0]           r_oq_byte [OQ_DEPTH];
    logic                 r_oq_last [OQ_DEPTH];
    logic [OQ_PTR_W-1:0]  r_wptr, r_rptr;
    logic [OQ_CNT_W-1:0]  r_ocnt;

    logic                 start;
    logic                 issue;
    logic                 room;
    logic                 is_last;
    logic [7:0]           byte_val;
    logic [7:0]           factor;
    logic [15:0]          quot_sum;
    logic                 oq_pop;
    logic [FRAME_W-1:0]   data_len;

    assign room     = ({1'b0, r_ocnt} + (OQ_CNT_W+1)'(r_pv)) < (OQ_CNT_W+1)'(OQ_DEPTH);
    assign is_last  = (r_cnt == r_total - FRAME_W'(1));
    assign byte_val = (r_cnt < FRAME_W'(r_ndata)) ? r_store[r_pix][{r_slot, 3'b000} +: 8]
                                                  : 8'd0;
    assign factor   = r_scaled ? i_cfg.brightness : FULL_SCALE;
    assign data_len = FRAME_W'({i_cfg.pixels, 1'b0}) + FRAME_W'(i_cfg.pixels);

    always_comb begin
        n_state   = r_state;
        n_store   = r_store;
        n_rem     = r_rem;
        n_cnt     = r_cnt;
        n_total   = r_total;
        n_ndata   = r_ndata;
        n_pix     = r_pix;
        n_slot    = r_slot;
        n_scaled  = r_scaled;
        o_cmd_pop = 1'b0;
        start     = 1'b0;
        issue     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (!i_cmd_empty) begin
                    o_cmd_pop = 1'b1;
                    case (i_cmd.op)
                        OP_SET: n_store[i_cmd.idx] = i_cmd.pixel;
                        OP_FILL: begin
                            for (int j = 0; j < MAX_PIXELS; j++) begin
                                if (CNT_W'(j) < i_cfg.pixels) begin
                                    n_store[j] = i_cmd.pixel;
                                end
                            end
                            start    = 1'b1;
                            n_scaled = 1'b0;
                        end
                        OP_ROTATE: begin
                            if (i_cmd.steps != '0) begin
                                n_rem   = i_cmd.steps;
                                n_state = ST_ROTATE;
                            end
                        end
                        default: begin
                            start    = 1'b1;
                            n_scaled = 1'b1;
                        end
                    endcase
                end
            end
            ST_ROTATE: begin
                // one pixel left per cycle over the pixels in use
                for (int j = 0; j < MAX_PIXELS; j++) begin
                    if (CNT_W'(j) == i_cfg.pixels - CNT_W'(1)) begin
                        n_store[j] = r_store[0];
                    end else if (CNT_W'(j) < i_cfg.pixels) begin
                        n_store[j] = r_store[PIX_IDX_W'(j + 1)];
                    end
                end
                n_rem = r_rem - 1'b1;
                if (r_rem == PIX_IDX_W'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (room) begin
                    issue = 1'b1;
                    n_cnt = r_cnt + 1'b1;
                    if (r_slot == 2'd2) begin
                        n_slot = 2'd0;
                        n_pix  = r_pix + 1'b1;
                    end else begin
                        n_slot = r_slot + 1'b1;
                    end
                    if (is_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
        if (start) begin
            n_cnt   = '0;
            n_pix   = '0;
            n_slot  = 2'd0;
            n_ndata = DATA_W'(data_len);
            n_total = data_len + FRAME_W'(i_cfg.trailer);
            n_state = ST_EMIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < MAX_PIXELS; j++) begin
                r_store[j] <= '0;
            end
            r_pv   <= 1'b0;
            r_wptr <= '0;
            r_rptr <= '0;
            r_ocnt <= '0;
        end else begin
            r_store <= n_store;
            r_pv    <= issue;
            if (r_pv) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (oq_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_ocnt <= r_ocnt + OQ_CNT_W'(r_pv) - OQ_CNT_W'(oq_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem    <= n_rem;
        r_cnt    <= n_cnt;
        r_total  <= n_total;
        r_ndata  <= n_ndata;
        r_pix    <= n_pix;
        r_slot   <= n_slot;
        r_scaled <= n_scaled;
        if (issue) begin
            r_prod  <= 16'(byte_val) * 16'(factor);
            r_plast <= is_last;
        end
        if (r_pv) begin
            r_oq_byte[r_wptr] <= quot_sum[15:8];
            r_oq_last[r_wptr] <= r_plast;
        end
    end

    // floor(x / 255) for x up to 255 * 255
    assign quot_sum = r_prod + {8'd0, r_prod[15:8]} + 16'd1;

    assign oq_pop      = i_pop && (r_ocnt != '0);
    assign o_empty     = (r_ocnt == '0);
    assign o_out_byte  = r_oq_byte[r_rptr];
    assign o_last_byte = r_oq_last[r_rptr];

    `LSFE_ASSERT(a_oq_bound, i_clk, i_rst_n, r_ocnt <= OQ_CNT_W'(OQ_DEPTH), "output queue overrun")
    `LSFE_ASSERT(a_scale_room, i_clk, i_rst_n, r_pv |-> (r_ocnt < OQ_CNT_W'(OQ_DEPTH)), "no room for scaled item")
    `LSFE_ASSERT(a_rot_nonzero, i_clk, i_rst_n, (r_state == ST_ROTATE) |-> (r_rem != '0), "rotate with no steps left")
    `LSFE_ASSERT(a_emit_range, i_clk, i_rst_n, (r_state == ST_EMIT) |-> (r_cnt < r_total), "emit past frame end")
    `LSFE_ASSERT(a_idle_no_issue, i_clk, i_rst_n, (r_state != ST_EMIT) |=> !r_pv, "scale stage loaded outside emit")

endmodule
`default_nettype wire

[hdl/led_strip_frame_engine.sv]
// Frame engine for an addressable RGB LED strip: config registers, front end,
// command queue and back end. Depends on lsfe_pkg, lsfe_front, lsfe_cmd_fifo, lsfe_back.
// Requests are taken one at a time by the front end, which stays full until the command is
// queued; a rotate first reduces its steps modulo the pixel count, one step bit at a time.
// The back end then writes a pixel, turns the strip one pixel per cycle, and emits a frame
// at one byte per cycle while the output queue has room, pixel_count*3 + trailer_bytes bytes
// (at most 64), each byte registered in the scale stage before the queue. A two-entry command
// queue lets the next request be decoded while a frame goes out. The pixel store resets to all zeros.
`default_nettype none
module led_strip_frame_engine
    import lsfe_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [ADDR_W-1:0]    paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    input  wire logic                 push,
    output logic                      full,
    input  wire logic [1:0]           i_req_type,
    input  wire logic [PIX_IDX_W-1:0] i_pixel_index,
    input  wire logic [7:0]           i_red,
    input  wire logic [7:0]           i_green,
    input  wire logic [7:0]           i_blue,
    input  wire logic [STEPS_W-1:0]   i_rotate_steps,
    output logic                      empty,
    input  wire logic                 pop,
    output logic [7:0]                o_out_byte,
    output logic                      o_last_byte
);

    logic [1:0] r_slot0, r_slot1, r_slot2;
    logic [4:0] r_pixel_count;
    logic [4:0] r_trailer;
    logic [7:0] r_brightness;

    logic       wr_en;
    logic [2:0] reg_idx;
    t_cfg       cfg;
    t_cmd       front_cmd, q_cmd;
    logic       q_push, q_full, q_pop, q_empty;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot0       <= COLOR_GREEN;
            r_slot1       <= COLOR_RED;
            r_slot2       <= COLOR_BLUE;
            r_pixel_count <= 5'(MAX_PIXELS);
            r_trailer     <= 5'd0;
            r_brightness  <= FULL_SCALE;
        end else if (wr_en) begin
            case (reg_idx)
                REG_SLOT0:      r_slot0       <= pwdata[1:0];
                REG_SLOT1:      r_slot1       <= pwdata[1:0];
                REG_SLOT2:      r_slot2       <= pwdata[1:0];
                REG_PIXELS:     r_pixel_count <= pwdata[4:0];
                REG_TRAILER:    r_trailer     <= pwdata[4:0];
                REG_BRIGHTNESS: r_brightness  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_SLOT0:      prdata = {30'd0, r_slot0};
            REG_SLOT1:      prdata = {30'd0, r_slot1};
            REG_SLOT2:      prdata = {30'd0, r_slot2};
            REG_PIXELS:     prdata = {27'd0, r_pixel_count};
            REG_TRAILER:    prdata = {27'd0, r_trailer};
            REG_BRIGHTNESS: prdata = {24'd0, r_brightness};
            default:        prdata = 32'd0;
        endcase
    end

    always_comb begin
        cfg.slot0 = r_slot0;
        cfg.slot1 = r_slot1;
        cfg.slot2 = r_slot2;
        if (r_pixel_count == 5'd0) begin
            cfg.pixels = CNT_W'(1);
        end else if (r_pixel_count > 5'(MAX_PIXELS)) begin
            cfg.pixels = CNT_W'(MAX_PIXELS);
        end else begin
            cfg.pixels = CNT_W'(r_pixel_count);
        end
        cfg.trailer    = (r_trailer > 5'(MAX_TRAILER)) ? TRL_W'(MAX_TRAILER)
                                                       : TRL_W'(r_trailer);
        cfg.brightness = r_brightness;
    end

    lsfe_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_push         (push),
        .o_full         (full),
        .i_req_type     (i_req_type),
        .i_pixel_index  (i_pixel_index),
        .i_red          (i_red),
        .i_green        (i_green),
        .i_blue         (i_blue),
        .i_rotate_steps (i_rotate_steps),
        .i_q_full       (q_full),
        .o_q_push       (q_push),
        .o_cmd          (front_cmd)
    );

    lsfe_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cmd   (q_cmd)
    );

    lsfe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd_empty (q_empty),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (q_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_out_byte  (o_out_byte),
        .o_last_byte (o_last_byte)
    );

endmodule
`default_nettype wire

[tb/sv/led_strip_frame_checker.sv]
// Checker for the LED strip frame engine: watches the APB, request and frame-byte channels,
// keeps its own copy of the settings and pixel store, and compares every emitted byte.
// Depends on lsfe_pkg.
`timescale 1ns / 100ps
`default_nettype none
module led_strip_frame_checker
    import lsfe_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_psel,
    input  wire logic                 i_penable,
    input  wire logic                 i_pwrite,
    input  wire logic [ADDR_W-1:0]    i_paddr,
    input  wire logic [31:0]          i_pwdata,
    input  wire logic                 i_pready,
    input  wire logic                 i_push,
    input  wire logic                 i_full,
    input  wire logic [1:0]           i_req_type,
    input  wire logic [PIX_IDX_W-1:0] i_pixel_index,
    input  wire logic [7:0]           i_red,
    input  wire logic [7:0]           i_green,
    input  wire logic [7:0]           i_blue,
    input  wire logic [STEPS_W-1:0]   i_rotate_steps,
    input  wire logic                 i_empty,
    input  wire logic                 i_pop,
    input  wire logic [7:0]           i_out_byte,
    input  wire logic                 i_last_byte,
    output int                        o_fail_count,
    output int                        o_pending,
    output int                        o_bytes_checked
);

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } t_frame_byte;

    t_frame_byte frame_q[$];
    logic [1:0]  slot_sel [3];
    logic [4:0]  count_reg;
    logic [4:0]  trailer_reg;
    logic [7:0]  bright_reg;
    logic [23:0] strip [MAX_PIXELS];
    int          fails;
    int          checked;

    function automatic int pixels_used();
        if (count_reg == 5'd0) return 1;
        if (count_reg > MAX_PIXELS) return MAX_PIXELS;
        return int'(count_reg);
    endfunction

    function automatic int trailer_used();
        if (trailer_reg > MAX_TRAILER) return MAX_TRAILER;
        return int'(trailer_reg);
    endfunction

    function automatic logic [7:0] channel(input logic [1:0] sel, input logic [7:0] r,
                                           input logic [7:0] g, input logic [7:0] b);
        if (sel == COLOR_RED) return r;
        if (sel == COLOR_GREEN) return g;
        if (sel == COLOR_BLUE) return b;
        return 8'd0;
    endfunction

    function automatic logic [23:0] wire_pixel(input logic [7:0] r, input logic [7:0] g,
                                               input logic [7:0] b);
        return {channel(slot_sel[2], r, g, b), channel(slot_sel[1], r, g, b),
                channel(slot_sel[0], r, g, b)};
    endfunction

    function automatic void queue_frame(input bit scaled);
        int n;
        int total;
        int v;
        t_frame_byte fb;
        n = pixels_used();
        total = n * 3 + trailer_used();
        for (int i = 0; i < total; i++) begin
            v = 0;
            if (i < n * 3) begin
                v = int'(strip[i / 3][8 * (i % 3) +: 8]);
                if (scaled) v = (v * int'(bright_reg)) / int'(FULL_SCALE);
            end
            fb.value = v[7:0];
            fb.last = (i + 1 == total);
            frame_q.push_back(fb);
        end
    endfunction

    function automatic void turn_left(input logic [STEPS_W-1:0] steps);
        logic [23:0] moved [MAX_PIXELS];
        int n;
        int s;
        n = pixels_used();
        s = int'(steps) % n;
        for (int i = 0; i < n; i++) moved[i] = strip[(i + s) % n];
        for (int i = 0; i < n; i++) strip[i] = moved[i];
    endfunction

    always @(posedge i_clk) begin
        int n;
        int slot;
        t_frame_byte want;
        if (!i_rst_n) begin
            slot_sel[0] = COLOR_GREEN;
            slot_sel[1] = COLOR_RED;
            slot_sel[2] = COLOR_BLUE;
            count_reg   = 5'd16;
            trailer_reg = 5'd0;
            bright_reg  = 8'd255;
            for (int i = 0; i < MAX_PIXELS; i++) strip[i] = 24'd0;
            frame_q.delete();
            fails = 0;
            checked = 0;
        end else begin
            if (i_pop && !i_empty) begin
                checked++;
                if (frame_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("%0t: unexpected frame byte %02h last %0b", $realtime,
                                 i_out_byte, i_last_byte);
                end else begin
                    want = frame_q.pop_front();
                    if (want.value !== i_out_byte || want.last !== i_last_byte) begin
                        fails++;
                        if (fails <= 10)
                            $display("%0t: frame byte mismatch: expected %02h last %0b, got %02h last %0b",
                                     $realtime, want.value, want.last, i_out_byte, i_last_byte);
                    end
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[ADDR_W-1:2])
                    REG_SLOT0:      slot_sel[0] = i_pwdata[1:0];
                    REG_SLOT1:      slot_sel[1] = i_pwdata[1:0];
                    REG_SLOT2:      slot_sel[2] = i_pwdata[1:0];
                    REG_PIXELS:     count_reg   = i_pwdata[4:0];
                    REG_TRAILER:    trailer_reg = i_pwdata[4:0];
                    REG_BRIGHTNESS: bright_reg  = i_pwdata[7:0];
                    default: ;
                endcase
            end
            if (i_push && !i_full) begin
                n = pixels_used();
                case (t_op'(i_req_type))
                    OP_SET: begin
                        slot = (int'(i_pixel_index) >= n) ? n - 1 : int'(i_pixel_index);
                        strip[slot] = wire_pixel(i_red, i_green, i_blue);
                    end
                    OP_FILL: begin
                        for (int i = 0; i < n; i++) strip[i] = wire_pixel(i_red, i_green, i_blue);
                        queue_frame(1'b0);
                    end
                    OP_ROTATE: turn_left(i_rotate_steps);
                    default:   queue_frame(1'b1);
                endcase
            end
        end
        o_fail_count    <= fails;
        o_pending       <= frame_q.size();
        o_bytes_checked <= checked;
    end

endmodule
`default_nettype wire

[tb/sv/led_strip_frame_engine_tb.sv]
// Top of the LED strip frame engine regression: clock, reset, APB settings, request stimulus
// and frame-byte backpressure. Depends on lsfe_pkg, led_strip_frame_engine and
// led_strip_frame_checker.
`timescale 1ns / 100ps
`default_nettype none
module led_strip_frame_engine_tb;
    import lsfe_pkg::*;

    localparam logic [1:0] COLOR_NONE = 2'd3;
    localparam int         CYCLE_LIMIT = 5_000_000;
    localparam int         SETTLE = 200;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_W-1:0]    paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 push = 1'b0;
    logic                 full;
    logic [1:0]           i_req_type = OP_SET;
    logic [PIX_IDX_W-1:0] i_pixel_index = '0;
    logic [7:0]           i_red = '0;
    logic [7:0]           i_green = '0;
    logic [7:0]           i_blue = '0;
    logic [STEPS_W-1:0]   i_rotate_steps = '0;
    logic                 empty;
    logic                 pop = 1'b0;
    logic [7:0]           o_out_byte;
    logic                 o_last_byte;

    int fail_count;
    int pending;
    int bytes_checked;
    int cycles = 0;
    int items_sent = 0;
    int settings_used = 0;
    int pop_hold = 0;
    bit calm = 1'b0;
    int cur_pixels = 16;

    led_strip_frame_engine u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .push           (push),
        .full           (full),
        .i_req_type     (i_req_type),
        .i_pixel_index  (i_pixel_index),
        .i_red          (i_red),
        .i_green        (i_green),
        .i_blue         (i_blue),
        .i_rotate_steps (i_rotate_steps),
        .empty          (empty),
        .pop            (pop),
        .o_out_byte     (o_out_byte),
        .o_last_byte    (o_last_byte)
    );

    led_strip_frame_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .i_pready        (pready),
        .i_push          (push),
        .i_full          (full),
        .i_req_type      (i_req_type),
        .i_pixel_index   (i_pixel_index),
        .i_red           (i_red),
        .i_green         (i_green),
        .i_blue          (i_blue),
        .i_rotate_steps  (i_rotate_steps),
        .i_empty         (empty),
        .i_pop           (pop),
        .i_out_byte      (o_out_byte),
        .i_last_byte     (o_last_byte),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_bytes_checked (bytes_checked)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("led_strip_frame_engine regression: fail");
            $finish;
        end
    end

    // mostly short stalls, the odd long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    always @(posedge i_clk) begin
        if (pop_hold != 0) begin
            pop <= 1'b0;
            pop_hold <= pop_hold - 1;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            pop <= 1'b0;
            pop_hold <= gap_len() - 1;
        end else begin
            pop <= 1'b1;
        end
    end

    task automatic push_item(input t_op op, input logic [PIX_IDX_W-1:0] idx,
                             input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                             input logic [STEPS_W-1:0] steps);
        int gap;
        push <= 1'b1;
        i_req_type <= op;
        i_pixel_index <= idx;
        i_red <= r;
        i_green <= g;
        i_blue <= b;
        i_rotate_steps <= steps;
        do @(posedge i_clk); while (full);
        items_sent++;
        gap = (calm || $urandom_range(0, 1) == 0) ? 0 : gap_len();
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [1:0] s0, input logic [1:0] s1, input logic [1:0] s2,
                             input logic [4:0] count, input logic [4:0] trailer,
                             input logic [7:0] bright);
        wait_idle();
        write_reg(REG_SLOT0, 32'(s0));
        write_reg(REG_SLOT1, 32'(s1));
        write_reg(REG_SLOT2, 32'(s2));
        write_reg(REG_PIXELS, 32'(count));
        write_reg(REG_TRAILER, 32'(trailer));
        write_reg(REG_BRIGHTNESS, 32'(bright));
        cur_pixels = (count == 0) ? 1 : (count > MAX_PIXELS) ? MAX_PIXELS : int'(count);
        settings_used++;
    endtask

    function automatic logic [7:0] rand_level();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 8'd0;
        if (r == 1) return 8'd255;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [1:0] rand_slot();
        if ($urandom_range(0, 9) == 0) return COLOR_NONE;
        return 2'($urandom_range(0, 2));
    endfunction

    function automatic logic [4:0] rand_span(input int top);
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return 5'(top == MAX_PIXELS ? 1 : 0);
        if (r < 30) return 5'(top);
        if (r < 40) return ($urandom_range(0, 2) == 0) ? 5'd0 : 5'($urandom_range(17, 31));
        return 5'($urandom_range(top == MAX_PIXELS ? 1 : 0, top));
    endfunction

    task automatic random_item();
        int r;
        t_op op;
        logic [STEPS_W-1:0] steps;
        r = $urandom_range(0, 99);
        op = (r < 35) ? OP_SET : (r < 50) ? OP_FILL : (r < 70) ? OP_ROTATE : OP_SHOW;
        r = $urandom_range(0, 99);
        if (r < 25) steps = 16'($urandom_range(0, 40));
        else if (r < 45) steps = 16'($urandom_range(0, 4) * cur_pixels);
        else if (r < 55) steps = 16'hFFFF;
        else steps = 16'($urandom_range(0, 65535));
        push_item(op, 4'($urandom_range(0, 15)), rand_level(), rand_level(), rand_level(),
                  steps);
    endtask

    initial begin
        logic [7:0] bright;
        int r;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // reset settings: empty store, then corners and rotations
        push_item(OP_SHOW, 4'd0, 8'd0, 8'd0, 8'd0, 16'd0);
        push_item(OP_SET, 4'd0, 8'hFF, 8'h00, 8'h00, 16'hFFFF);
        push_item(OP_SET, 4'd15, 8'h00, 8'hFF, 8'h00, 16'd0);
        push_item(OP_SET, 4'd5, 8'hAA, 8'h55, 8'hFF, 16'd0);
        push_item(OP_SHOW, 4'd15, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
        push_item(OP_ROTATE, 4'd0, 8'd0, 8'd0, 8'd0, 16'd0);
        push_item(OP_ROTATE, 4'd0, 8'd0, 8'd0, 8'd0, 16'd16);
        push_item(OP_ROTATE, 4'd0, 8'd0, 8'd0, 8'd0, 16'd1);
        push_item(OP_ROTATE, 4'd0, 8'd0, 8'd0, 8'd0, 16'hFFFF);
        push_item(OP_SHOW, 4'd0, 8'd0, 8'd0, 8'd0, 16'd0);
        push_item(OP_FILL, 4'd0, 8'hFF, 8'hFF, 8'hFF, 16'd0);
        push_item(OP_FILL, 4'd0, 8'h00, 8'h00, 8'h00, 16'd0);

        // short strip, long trailer, zero brightness, a dead wire slot
        configure(COLOR_RED, COLOR_BLUE, COLOR_NONE, 5'd3, 5'd16, 8'd0);
        push_item(OP_SET, 4'd15, 8'h12, 8'h34, 8'h56, 16'd0);
        push_item(OP_SET, 4'd0, 8'hFE, 8'h01, 8'h80, 16'd0);
        push_item(OP_SHOW, 4'd0, 8'd0, 8'd0, 8'd0, 16'd0);
        push_item(OP_ROTATE, 4'd0, 8'd0, 8'd0, 8'd0, 16'd2);
        push_item(OP_FILL, 4'd0, 8'h7F, 8'h80, 8'h01, 16'd0);

        // count zero acts as one, trailer clamps at its ceiling
        configure(COLOR_BLUE, COLOR_GREEN, COLOR_RED, 5'd0, 5'd31, 8'd128);
        push_item(OP_SET, 4'd9, 8'hC3, 8'h3C, 8'h99, 16'd0);
        push_item(OP_ROTATE, 4'd0, 8'd0, 8'd0, 8'd0, 16'hFFFF);
        push_item(OP_SHOW, 4'd0, 8'd0, 8'd0, 8'd0, 16'd0);

        // count above the strip clamps to the full store
        configure(COLOR_GREEN, COLOR_GREEN, COLOR_BLUE, 5'd31, 5'd17, 8'd1);
        push_item(OP_SHOW, 4'd0, 8'd0, 8'd0, 8'd0, 16'd0);
        push_item(OP_FILL, 4'd0, 8'hFF, 8'h0F, 8'hF0, 16'd0);
        push_item(OP_SHOW, 4'd0, 8'd0, 8'd0, 8'd0, 16'd0);

        for (int phase = 0; phase < 10; phase++) begin
            r = $urandom_range(0, 99);
            bright = (r < 20) ? 8'd0 : (r < 40) ? 8'd255 : (r < 50) ? 8'd1
                                                         : 8'($urandom_range(0, 255));
            configure(rand_slot(), rand_slot(), rand_slot(), rand_span(MAX_PIXELS),
                      rand_span(MAX_TRAILER), bright);
            calm <= ($urandom_range(0, 3) == 0);
            repeat (40) random_item();
            calm <= 1'b0;
        end

        wait_idle();
        $display("Sent %0d requests over %0d register settings; %0d frame bytes checked.",
                 items_sent, settings_used + 1, bytes_checked);
        if (fail_count == 0) begin
            $display("led_strip_frame_engine regression: pass");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("led_strip_frame_engine regression: fail");
        end
        $finish;
    end

endmodule
`default_nettype wire
